>>> rtl/dfa_merge_pkg.sv
// ----------------------------------------------------------------------------
// dfa_merge_pkg
// Shared constants, command codes, state and command/status types for the
// duplicate state merger.
// ----------------------------------------------------------------------------
package dfa_merge_pkg;

  localparam int DEF_MAX_ROWS    = 64;
  localparam int DEF_MAX_SYMBOLS = 16;
  localparam int DEF_LABEL_BITS  = 8;

  localparam logic [2:0] FN_LOAD_LABEL = 3'd0;
  localparam logic [2:0] FN_LOAD_TGT   = 3'd1;
  localparam logic [2:0] FN_RUN        = 3'd2;
  localparam logic [2:0] FN_READ_LABEL = 3'd3;
  localparam logic [2:0] FN_READ_TGT   = 3'd4;

  localparam logic [1:0] CFG_NONFINAL = 2'd0;
  localparam logic [1:0] CFG_FINAL    = 2'd1;
  localparam logic [1:0] CFG_SYMBOLS  = 2'd2;

  typedef enum logic [4:0] {
    S_IDLE,
    S_READ,
    S_GRP_START,
    S_CMP_A,
    S_CMP_B,
    S_CMP_C,
    S_NEXT_PAIR,
    S_LAB_J,
    S_LAB_I,
    S_LAB_GOT,
    S_RED_NEXT,
    S_RED_RD,
    S_RED_WR,
    S_SH_NEXT,
    S_SH_RD,
    S_SH_WR,
    S_SHL_RD,
    S_SHL_WR,
    S_DEC
  } state_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_ACCEPT,
    DP_READ_OUT,
    DP_GRP_NEXT,
    DP_FINISH,
    DP_PAIR_INIT,
    DP_CMP_RDA,
    DP_CMP_RDB,
    DP_CMP_STEP,
    DP_PAIR_NEXT,
    DP_LAB_RDJ,
    DP_LAB_RDI,
    DP_LAB_GOT,
    DP_RED_GRP,
    DP_RED_ROW,
    DP_RED_RD,
    DP_RED_WR,
    DP_SH_INIT,
    DP_SH_RD,
    DP_SH_WR,
    DP_SHL_RD,
    DP_SHL_WR,
    DP_DEC
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic cnt_lt2;
    logic grp_last;
    logic ns_zero;
    logic col_last;
    logic cmp_eq;
    logic pair_last;
    logic red_end;
    logic red_row_end;
    logic red_col_end;
    logic sh_done;
    logic sh_col_last;
  } dp_status_t;

endpackage

>>> rtl/dfa_duplicate_state_merger_unit.sv
// load requests and unused codes: the result is registered in the cycle after acceptance
// read requests: registered memory read, then the output register; one request at a time
// run: compares row pairs column by column, redirects matching targets in both
//   groups and moves later rows up, all on the single memory ports
// reset clears the row counts to zero, symbol count to one and the output
// valid flag; label and target memories are not cleared
// ----------------------------------------------------------------------------
// dfa_duplicate_state_merger_unit
// Finite automaton row merger: loads a two-group transition table and merges
// rows with identical transitions until none remain.
// ----------------------------------------------------------------------------
module dfa_duplicate_state_merger_unit
  import dfa_merge_pkg::*;
#(
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS,
  parameter int LABEL_BITS  = DEF_LABEL_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] in_func,
  input  logic       in_group,
  input  logic [5:0] in_row,
  input  logic [3:0] in_symbol,
  input  logic [7:0] in_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_read_value,
  output logic [6:0] out_nonfinal_left,
  output logic [6:0] out_final_left,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t st;

  dfa_merge_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  dfa_merge_dp #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .LABEL_BITS  (LABEL_BITS)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_func           (in_func),
    .in_group          (in_group),
    .in_row            (in_row),
    .in_symbol         (in_symbol),
    .in_value          (in_value),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_read_value    (out_read_value),
    .out_nonfinal_left (out_nonfinal_left),
    .out_final_left    (out_final_left),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .cmd               (cmd),
    .st                (st)
  );

  // a request is only taken when the output register can take its result
  a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> (!out_valid || !out_stall))
    else $error("request accepted while result register is full");

  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_func == FN_LOAD_LABEL || in_func == FN_LOAD_TGT))
    |=> out_valid)
    else $error("load request produced no result");

  a_read_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && (in_func == FN_READ_LABEL || in_func == FN_READ_TGT ||
                               in_func == FN_RUN))
    |=> in_stall)
    else $error("new request taken while read or run is in progress");

endmodule

>>> rtl/dfa_merge_ctrl.sv
// ----------------------------------------------------------------------------
// dfa_merge_ctrl
// Sequencer for load/read requests and the row merge search, redirect and
// row removal sweeps.
// ----------------------------------------------------------------------------
module dfa_merge_ctrl
  import dfa_merge_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] in_func,
  output logic       in_stall,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd.op    = DP_NOP;
    in_stall  = !((state_r == S_IDLE) && st.out_free);
    case (state_r)
      S_IDLE: begin
        if (in_valid && st.out_free) begin
          cmd.op = DP_ACCEPT;
          case (in_func)
            FN_READ_LABEL, FN_READ_TGT: state_nxt = S_READ;
            FN_RUN:                     state_nxt = S_GRP_START;
            default:                    state_nxt = S_IDLE;
          endcase
        end
      end
      S_READ: begin
        cmd.op    = DP_READ_OUT;
        state_nxt = S_IDLE;
      end
      S_GRP_START: begin
        if (st.cnt_lt2) begin
          if (st.grp_last) begin
            cmd.op    = DP_FINISH;
            state_nxt = S_IDLE;
          end else begin
            cmd.op = DP_GRP_NEXT;
          end
        end else begin
          cmd.op    = DP_PAIR_INIT;
          state_nxt = S_CMP_A;
        end
      end
      S_CMP_A: begin
        // no columns to compare: every pair matches
        if (st.ns_zero) begin
          state_nxt = S_LAB_J;
        end else begin
          cmd.op    = DP_CMP_RDA;
          state_nxt = S_CMP_B;
        end
      end
      S_CMP_B: begin
        cmd.op    = DP_CMP_RDB;
        state_nxt = S_CMP_C;
      end
      S_CMP_C: begin
        if (!st.cmp_eq) begin
          state_nxt = S_NEXT_PAIR;
        end else if (st.col_last) begin
          state_nxt = S_LAB_J;
        end else begin
          cmd.op    = DP_CMP_STEP;
          state_nxt = S_CMP_A;
        end
      end
      S_NEXT_PAIR: begin
        if (st.pair_last) begin
          if (st.grp_last) begin
            cmd.op    = DP_FINISH;
            state_nxt = S_IDLE;
          end else begin
            cmd.op    = DP_GRP_NEXT;
            state_nxt = S_GRP_START;
          end
        end else begin
          cmd.op    = DP_PAIR_NEXT;
          state_nxt = S_CMP_A;
        end
      end
      S_LAB_J: begin
        cmd.op    = DP_LAB_RDJ;
        state_nxt = S_LAB_I;
      end
      S_LAB_I: begin
        cmd.op    = DP_LAB_RDI;
        state_nxt = S_LAB_GOT;
      end
      S_LAB_GOT: begin
        cmd.op    = DP_LAB_GOT;
        state_nxt = S_RED_NEXT;
      end
      S_RED_NEXT: begin
        if (st.red_end) begin
          cmd.op    = DP_SH_INIT;
          state_nxt = S_SH_NEXT;
        end else if (st.red_row_end) begin
          cmd.op = DP_RED_GRP;
        end else if (st.red_col_end) begin
          cmd.op = DP_RED_ROW;
        end else begin
          state_nxt = S_RED_RD;
        end
      end
      S_RED_RD: begin
        cmd.op    = DP_RED_RD;
        state_nxt = S_RED_WR;
      end
      S_RED_WR: begin
        cmd.op    = DP_RED_WR;
        state_nxt = S_RED_NEXT;
      end
      S_SH_NEXT: begin
        state_nxt = st.sh_done ? S_DEC : S_SH_RD;
      end
      S_SH_RD: begin
        cmd.op    = DP_SH_RD;
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        cmd.op    = DP_SH_WR;
        state_nxt = st.sh_col_last ? S_SHL_RD : S_SH_RD;
      end
      S_SHL_RD: begin
        cmd.op    = DP_SHL_RD;
        state_nxt = S_SHL_WR;
      end
      S_SHL_WR: begin
        cmd.op    = DP_SHL_WR;
        state_nxt = S_SH_NEXT;
      end
      S_DEC: begin
        cmd.op    = DP_DEC;
        state_nxt = S_GRP_START;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/dfa_merge_dp.sv
// ----------------------------------------------------------------------------
// dfa_merge_dp
// Label and target memories, row counts, loop counters, compare logic and
// the output register.
// ----------------------------------------------------------------------------
module dfa_merge_dp
  import dfa_merge_pkg::*;
#(
  parameter int MAX_ROWS    = DEF_MAX_ROWS,
  parameter int MAX_SYMBOLS = DEF_MAX_SYMBOLS,
  parameter int LABEL_BITS  = DEF_LABEL_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [2:0] in_func,
  input  logic       in_group,
  input  logic [5:0] in_row,
  input  logic [3:0] in_symbol,
  input  logic [7:0] in_value,
  input  logic       out_stall,
  output logic       out_valid,
  output logic [7:0] out_read_value,
  output logic [6:0] out_nonfinal_left,
  output logic [6:0] out_final_left,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data,
  input  dp_cmd_t    cmd,
  output dp_status_t st
);

  localparam int ROW_W  = $clog2(MAX_ROWS);
  localparam int CNT_W  = $clog2(MAX_ROWS + 1);
  localparam int SYM_W  = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam int SYMC_W = $clog2(MAX_SYMBOLS + 1);
  localparam int LA_W   = 1 + ROW_W;
  localparam int TA_W   = 1 + ROW_W + SYM_W;

  logic [LABEL_BITS-1:0] lab_mem [2**LA_W];
  logic [LABEL_BITS-1:0] tgt_mem [2**TA_W];

  logic [LABEL_BITS-1:0] lab_q_r, tgt_q_r;
  logic [LABEL_BITS-1:0] a_r, from_r, to_r;
  logic [CNT_W-1:0]      nf_rows_r, fi_rows_r;
  logic [4:0]            sym_r;
  logic                  g_r;
  logic [1:0]            gg_r;
  logic [CNT_W-1:0]      i_r, j_r, k_r, r_r;
  logic [SYMC_W-1:0]     c_r;
  logic                  rd_zero_r, rd_sel_r;

  logic                  out_valid_r;
  logic [7:0]            out_rd_r;
  logic [6:0]            out_nf_r, out_fi_r;

  logic [SYMC_W-1:0]     ns;
  logic [CNT_W-1:0]      cnt_g, cnt_in, cnt_gg, k_p1;
  logic [LABEL_BITS-1:0] val;
  logic                  row_ok, sym_ok;

  logic                  lab_we, lab_re, tgt_we, tgt_re;
  logic [LA_W-1:0]       lab_waddr, lab_raddr;
  logic [TA_W-1:0]       tgt_waddr, tgt_raddr;
  logic [LABEL_BITS-1:0] lab_wdata, tgt_wdata;
  logic                  out_load;
  logic [7:0]            out_rd_nxt;

  assign ns     = (32'(sym_r) > MAX_SYMBOLS) ? SYMC_W'(MAX_SYMBOLS) : SYMC_W'(sym_r);
  assign cnt_g  = g_r ? fi_rows_r : nf_rows_r;
  assign cnt_in = in_group ? fi_rows_r : nf_rows_r;
  assign cnt_gg = gg_r[0] ? fi_rows_r : nf_rows_r;
  assign k_p1   = k_r + 1'b1;
  assign val    = LABEL_BITS'(in_value);
  assign row_ok = 32'(in_row) < MAX_ROWS;
  assign sym_ok = 32'(in_symbol) < MAX_SYMBOLS;

  assign st.out_free    = !out_valid_r || !out_stall;
  assign st.cnt_lt2     = 32'(cnt_g) < 2;
  assign st.grp_last    = g_r;
  assign st.ns_zero     = (ns == '0);
  assign st.col_last    = (32'(c_r) + 1) == 32'(ns);
  assign st.cmp_eq      = (tgt_q_r == a_r);
  assign st.pair_last   = (32'(j_r) + 1 >= 32'(cnt_g)) && (32'(i_r) + 2 >= 32'(cnt_g));
  assign st.red_end     = gg_r[1];
  assign st.red_row_end = (r_r >= cnt_gg);
  assign st.red_col_end = (c_r >= ns);
  assign st.sh_done     = (32'(k_r) + 1 >= 32'(cnt_g));
  assign st.sh_col_last = (32'(c_r) == MAX_SYMBOLS - 1);

  // memory port selection
  always_comb begin
    lab_we     = 1'b0;
    lab_re     = 1'b0;
    tgt_we     = 1'b0;
    tgt_re     = 1'b0;
    lab_waddr  = {in_group, ROW_W'(in_row)};
    lab_raddr  = {in_group, ROW_W'(in_row)};
    tgt_waddr  = {in_group, ROW_W'(in_row), SYM_W'(in_symbol)};
    tgt_raddr  = {in_group, ROW_W'(in_row), SYM_W'(in_symbol)};
    lab_wdata  = val;
    tgt_wdata  = val;
    out_load   = 1'b0;
    out_rd_nxt = '0;
    case (cmd.op)
      DP_ACCEPT: begin
        case (in_func)
          FN_LOAD_LABEL: begin
            lab_we   = row_ok;
            out_load = 1'b1;
          end
          FN_LOAD_TGT: begin
            tgt_we   = row_ok && sym_ok;
            out_load = 1'b1;
          end
          FN_READ_LABEL: lab_re = 1'b1;
          FN_READ_TGT:   tgt_re = 1'b1;
          FN_RUN:        out_load = 1'b0;
          default:       out_load = 1'b1;
        endcase
      end
      DP_READ_OUT: begin
        out_load   = 1'b1;
        out_rd_nxt = rd_zero_r ? 8'd0 : (rd_sel_r ? 8'(tgt_q_r) : 8'(lab_q_r));
      end
      DP_FINISH: out_load = 1'b1;
      DP_CMP_RDA: begin
        tgt_re    = 1'b1;
        tgt_raddr = {g_r, i_r[ROW_W-1:0], c_r[SYM_W-1:0]};
      end
      DP_CMP_RDB: begin
        tgt_re    = 1'b1;
        tgt_raddr = {g_r, j_r[ROW_W-1:0], c_r[SYM_W-1:0]};
      end
      DP_LAB_RDJ: begin
        lab_re    = 1'b1;
        lab_raddr = {g_r, j_r[ROW_W-1:0]};
      end
      DP_LAB_RDI: begin
        lab_re    = 1'b1;
        lab_raddr = {g_r, i_r[ROW_W-1:0]};
      end
      DP_RED_RD: begin
        tgt_re    = 1'b1;
        tgt_raddr = {gg_r[0], r_r[ROW_W-1:0], c_r[SYM_W-1:0]};
      end
      DP_RED_WR: begin
        tgt_we    = (tgt_q_r == from_r);
        tgt_waddr = {gg_r[0], r_r[ROW_W-1:0], c_r[SYM_W-1:0]};
        tgt_wdata = to_r;
      end
      DP_SH_RD: begin
        tgt_re    = 1'b1;
        tgt_raddr = {g_r, k_p1[ROW_W-1:0], c_r[SYM_W-1:0]};
      end
      DP_SH_WR: begin
        tgt_we    = 1'b1;
        tgt_waddr = {g_r, k_r[ROW_W-1:0], c_r[SYM_W-1:0]};
        tgt_wdata = tgt_q_r;
      end
      DP_SHL_RD: begin
        lab_re    = 1'b1;
        lab_raddr = {g_r, k_p1[ROW_W-1:0]};
      end
      DP_SHL_WR: begin
        lab_we    = 1'b1;
        lab_waddr = {g_r, k_r[ROW_W-1:0]};
        lab_wdata = lab_q_r;
      end
      default: begin
        out_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (lab_we) begin
      lab_mem[lab_waddr] <= lab_wdata;
    end
    if (lab_re) begin
      lab_q_r <= lab_mem[lab_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (tgt_we) begin
      tgt_mem[tgt_waddr] <= tgt_wdata;
    end
    if (tgt_re) begin
      tgt_q_r <= tgt_mem[tgt_raddr];
    end
  end

  // row counts and symbol count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nf_rows_r <= '0;
      fi_rows_r <= '0;
      sym_r     <= 5'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NONFINAL: nf_rows_r <= (32'(cfg_data) > MAX_ROWS) ? CNT_W'(MAX_ROWS)
                                                              : CNT_W'(cfg_data);
        CFG_FINAL:    fi_rows_r <= (32'(cfg_data) > MAX_ROWS) ? CNT_W'(MAX_ROWS)
                                                              : CNT_W'(cfg_data);
        CFG_SYMBOLS:  sym_r <= cfg_data[4:0];
        default:      sym_r <= sym_r;
      endcase
    end else if (cmd.op == DP_DEC) begin
      if (g_r) begin
        fi_rows_r <= fi_rows_r - 1'b1;
      end else begin
        nf_rows_r <= nf_rows_r - 1'b1;
      end
    end
  end

  // loop counters
  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_ACCEPT: begin
        g_r       <= 1'b0;
        rd_sel_r  <= (in_func == FN_READ_TGT);
        rd_zero_r <= !((32'(in_row) < 32'(cnt_in)) &&
                       ((in_func != FN_READ_TGT) || (32'(in_symbol) < 32'(ns))));
      end
      DP_GRP_NEXT: g_r <= 1'b1;
      DP_PAIR_INIT: begin
        i_r <= '0;
        j_r <= CNT_W'(1);
        c_r <= '0;
      end
      DP_CMP_RDB:  a_r <= tgt_q_r;
      DP_CMP_STEP: c_r <= c_r + 1'b1;
      DP_PAIR_NEXT: begin
        c_r <= '0;
        if (32'(j_r) + 1 < 32'(cnt_g)) begin
          j_r <= j_r + 1'b1;
        end else begin
          i_r <= i_r + 1'b1;
          j_r <= i_r + CNT_W'(2);
        end
      end
      DP_LAB_RDI: from_r <= lab_q_r;
      DP_LAB_GOT: begin
        to_r <= lab_q_r;
        gg_r <= '0;
        r_r  <= '0;
        c_r  <= '0;
      end
      DP_RED_GRP: begin
        gg_r <= gg_r + 1'b1;
        r_r  <= '0;
        c_r  <= '0;
      end
      DP_RED_ROW: begin
        r_r <= r_r + 1'b1;
        c_r <= '0;
      end
      DP_RED_WR: c_r <= c_r + 1'b1;
      DP_SH_INIT: begin
        k_r <= j_r;
        c_r <= '0;
      end
      DP_SH_WR:  c_r <= st.sh_col_last ? '0 : c_r + 1'b1;
      DP_SHL_WR: k_r <= k_p1;
      default:   c_r <= c_r;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rd_r <= out_rd_nxt;
      out_nf_r <= 7'(nf_rows_r);
      out_fi_r <= 7'(fi_rows_r);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_read_value    = out_rd_r;
  assign out_nonfinal_left = out_nf_r;
  assign out_final_left    = out_fi_r;

endmodule

>>> tb/sv/tb_merge_checker.sv
// ----------------------------------------------------------------------------
// tb_merge_checker
// Watches the request, result and register ports of the row merger, keeps its
// own copy of the transition table, predicts each result and compares it.
// ----------------------------------------------------------------------------
module tb_merge_checker
  import dfa_merge_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [2:0] in_func,
  input  logic       in_group,
  input  logic [5:0] in_row,
  input  logic [3:0] in_symbol,
  input  logic [7:0] in_value,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_read_value,
  input  logic [6:0] out_nonfinal_left,
  input  logic [6:0] out_final_left,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [6:0] cfg_data,
  output int         errors,
  output int         waiting
);

  typedef struct packed {
    logic [7:0] read_value;
    logic [6:0] nonfinal_left;
    logic [6:0] final_left;
  } status_t;

  logic [7:0] labels [2][DEF_MAX_ROWS];
  logic [7:0] targets[2][DEF_MAX_ROWS][DEF_MAX_SYMBOLS];
  int         rows_now[2];
  int         symbols;   // already clipped to the column count
  status_t    pending[$];

  task automatic report(string field, int want, int got);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, field, want, got);
    errors++;
  endtask

  function automatic bit same_row(int g, int a, int b);
    for (int c = 0; c < symbols; c++)
      if (targets[g][a][c] != targets[g][b][c]) return 1'b0;
    return 1'b1;
  endfunction

  // pointers into the removed state move to the kept one, in both groups
  task automatic redirect(logic [7:0] from, logic [7:0] to);
    for (int g = 0; g < 2; g++)
      for (int r = 0; r < rows_now[g]; r++)
        for (int c = 0; c < symbols; c++)
          if (targets[g][r][c] == from) targets[g][r][c] = to;
  endtask

  task automatic merge_group(int g);
    bit found;
    found = 1'b1;
    while (found) begin
      found = 1'b0;
      for (int i = 0; i + 1 < rows_now[g] && !found; i++)
        for (int j = i + 1; j < rows_now[g] && !found; j++)
          if (same_row(g, i, j)) begin
            redirect(labels[g][j], labels[g][i]);
            for (int k = j; k + 1 < rows_now[g]; k++) begin
              labels[g][k] = labels[g][k+1];
              for (int c = 0; c < DEF_MAX_SYMBOLS; c++) targets[g][k][c] = targets[g][k+1][c];
            end
            rows_now[g]--;
            found = 1'b1;
          end
    end
  endtask

  task automatic predict();
    status_t s;
    int      g;
    g = in_group;
    s = '0;
    case (in_func)
      FN_LOAD_LABEL: labels[g][in_row] = in_value;
      FN_LOAD_TGT:   targets[g][in_row][in_symbol] = in_value;
      FN_RUN: begin
        merge_group(0);
        merge_group(1);
      end
      FN_READ_LABEL: if (in_row < rows_now[g]) s.read_value = labels[g][in_row];
      FN_READ_TGT:
        if (in_row < rows_now[g] && in_symbol < symbols)
          s.read_value = targets[g][in_row][in_symbol];
      default: ;
    endcase
    s.nonfinal_left = 7'(rows_now[0]);
    s.final_left    = 7'(rows_now[1]);
    pending.push_back(s);
  endtask

  always @(posedge clk) begin
    status_t want;
    if (!rst_n) begin
      errors   = 0;
      rows_now = '{0, 0};
      symbols  = 1;
      foreach (labels[g, r]) labels[g][r] = '0;
      foreach (targets[g, r, c]) targets[g][r][c] = '0;
      pending.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending.size() == 0) begin
          $display("[%0t] result with no request outstanding", $realtime);
          errors++;
        end else begin
          want = pending.pop_front();
          if (out_read_value !== want.read_value)
            report("read_value", want.read_value, out_read_value);
          if (out_nonfinal_left !== want.nonfinal_left)
            report("nonfinal_left", want.nonfinal_left, out_nonfinal_left);
          if (out_final_left !== want.final_left)
            report("final_left", want.final_left, out_final_left);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_NONFINAL: rows_now[0] = cfg_data > DEF_MAX_ROWS ? DEF_MAX_ROWS : cfg_data;
          CFG_FINAL:    rows_now[1] = cfg_data > DEF_MAX_ROWS ? DEF_MAX_ROWS : cfg_data;
          CFG_SYMBOLS:
            symbols = cfg_data[4:0] > DEF_MAX_SYMBOLS ? DEF_MAX_SYMBOLS : cfg_data[4:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) predict();
    end
    waiting = pending.size();
  end

endmodule

>>> tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// Row merger test: loads small automata per job, mixes loads, reads, merge
// runs and unused codes under random idling, and lets the checker judge.
// ----------------------------------------------------------------------------
module tb;
  import dfa_merge_pkg::*;

  localparam logic [2:0] FN_UNUSED_FIRST = 3'd5;
  localparam int         ITEM_GOAL       = 1450;
  localparam int         QUIET_LIMIT     = 5000000;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [2:0] in_func;
  logic       in_group;
  logic [5:0] in_row;
  logic [3:0] in_symbol;
  logic [7:0] in_value;
  logic       out_valid;
  logic       out_stall;
  logic [7:0] out_read_value;
  logic [6:0] out_nonfinal_left;
  logic [6:0] out_final_left;
  logic       cfg_we;
  logic [1:0] cfg_index;
  logic [6:0] cfg_data;
  int         errors;
  int         waiting;

  logic       quiet;      // no idling on either side
  logic       hold_req;
  logic       hold_done;
  int         hold_left;
  int         idle_cycles;
  int         items;
  int         runs;
  int         jobs;
  logic [7:0] job_labels[2][DEF_MAX_ROWS];

  dfa_duplicate_state_merger_unit dut (.*);

  tb_merge_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // receiver: random stalls, plus one long hold so the block backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= 300;
      hold_done <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(0, 99) < 34);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles", QUIET_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(logic [2:0] f, int g, int r, int s, int v);
    bit took;
    if (!quiet && $urandom_range(0, 99) < 34) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_func   <= f;
    in_group  <= g[0];
    in_row    <= r[5:0];
    in_symbol <= s[3:0];
    in_value  <= v[7:0];
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    items++;
    if (f == FN_RUN) runs++;
  endtask

  // registers only change once every result is back
  task automatic setup(int nf, int fi, int ns);
    in_valid <= 1'b0;
    do @(negedge clk); while (waiting != 0);
    repeat (6) @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= CFG_NONFINAL; cfg_data <= nf[6:0];
    @(posedge clk);
    cfg_index <= CFG_FINAL; cfg_data <= fi[6:0];
    @(posedge clk);
    cfg_index <= CFG_SYMBOLS; cfg_data <= ns[6:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // targets drawn from a few of the job's own labels, so rows often match
  function automatic int pick_label(int cnt[2], int pool);
    int g;
    g = (cnt[0] == 0) ? 1 : (cnt[1] == 0) ? 0 : $urandom_range(0, 1);
    return job_labels[g][$urandom_range(0, (cnt[g] < pool ? cnt[g] : pool) - 1)];
  endfunction

  // fill every row and column that a merge compares or a read returns
  task automatic load_job(int nf, int fi, int ns, int pool);
    int cnt[2];
    int cols;
    cnt[0] = nf > DEF_MAX_ROWS ? DEF_MAX_ROWS : nf;
    cnt[1] = fi > DEF_MAX_ROWS ? DEF_MAX_ROWS : fi;
    cols   = (ns % 32) > DEF_MAX_SYMBOLS ? DEF_MAX_SYMBOLS : ns % 32;
    for (int g = 0; g < 2; g++)
      for (int r = 0; r < cnt[g]; r++) begin
        job_labels[g][r] = 8'($urandom_range(0, 255));
        send(FN_LOAD_LABEL, g, r, 0, job_labels[g][r]);
      end
    for (int g = 0; g < 2; g++)
      for (int r = 0; r < cnt[g]; r++)
        for (int c = 0; c < cols; c++)
          if (cnt[0] + cnt[1] > 0 && $urandom_range(0, 9) < 8)
            send(FN_LOAD_TGT, g, r, c, pick_label(cnt, pool));
          else
            send(FN_LOAD_TGT, g, r, c, $urandom_range(0, 255));
  endtask

  task automatic mixed_traffic(int n, int nf, int fi);
    int g;
    int lim;
    int pick;
    for (int k = 0; k < n; k++) begin
      g    = $urandom_range(0, 1);
      lim  = (g ? fi : nf) > 0 ? (g ? fi : nf) : 1;
      pick = $urandom_range(0, 99);
      if (pick < 15)
        send(FN_LOAD_TGT, g, $urandom_range(0, 63), $urandom_range(0, 15),
             $urandom_range(0, 255));
      else if (pick < 22)
        send(FN_LOAD_LABEL, g, $urandom_range(0, 63), 0, $urandom_range(0, 255));
      else if (pick < 32)
        send(FN_RUN, g, $urandom_range(0, 63), $urandom_range(0, 15), $urandom_range(0, 255));
      else if (pick < 40)
        send(3'(FN_UNUSED_FIRST + $urandom_range(0, 2)), g, $urandom_range(0, 63),
             $urandom_range(0, 15), $urandom_range(0, 255));
      else if (pick < 60)
        send(FN_READ_LABEL, g, $urandom_range(0, 9) < 8 ? $urandom_range(0, lim - 1)
             : $urandom_range(0, 63), $urandom_range(0, 15), $urandom_range(0, 255));
      else
        send(FN_READ_TGT, g, $urandom_range(0, 9) < 8 ? $urandom_range(0, lim - 1)
             : $urandom_range(0, 63), $urandom_range(0, 15), $urandom_range(0, 255));
    end
  endtask

  initial begin
    int nf;
    int fi;
    int ns;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_func   = FN_LOAD_LABEL;
    in_group  = 1'b0;
    in_row    = '0;
    in_symbol = '0;
    in_value  = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_NONFINAL;
    cfg_data  = '0;
    quiet     = 1'b0;
    hold_req  = 1'b0;
    items     = 0;
    runs      = 0;
    jobs      = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: two rows per group, two symbols, field extremes
    setup(2, 2, 2);
    send(FN_LOAD_LABEL, 0, 0, 0, 8'h00);
    send(FN_LOAD_LABEL, 0, 1, 0, 8'hff);
    send(FN_LOAD_LABEL, 1, 0, 0, 8'h11);
    send(FN_LOAD_LABEL, 1, 1, 0, 8'h22);
    send(FN_LOAD_TGT, 0, 0, 0, 8'hff); send(FN_LOAD_TGT, 0, 0, 1, 8'h11);
    send(FN_LOAD_TGT, 0, 1, 0, 8'hff); send(FN_LOAD_TGT, 0, 1, 1, 8'h11);
    send(FN_LOAD_TGT, 1, 0, 0, 8'h00); send(FN_LOAD_TGT, 1, 0, 1, 8'hff);
    send(FN_LOAD_TGT, 1, 1, 0, 8'h22); send(FN_LOAD_TGT, 1, 1, 1, 8'h00);
    send(FN_LOAD_TGT, 1, 63, 15, 8'h5a);             // loaded past the row count
    send(FN_READ_LABEL, 0, 1, 0, 0);
    send(FN_READ_TGT, 1, 1, 1, 0);
    send(FN_READ_TGT, 1, 63, 15, 0);                 // row past count reads zero
    send(FN_READ_TGT, 0, 0, 15, 0);                  // column past count reads zero
    send(FN_UNUSED_FIRST, 0, 0, 0, 8'hff);
    send(FN_UNUSED_FIRST + 3'd1, 1, 63, 15, 8'haa);
    send(FN_UNUSED_FIRST + 3'd2, 0, 21, 5, 8'h55);
    send(FN_RUN, 0, 0, 0, 0);
    send(FN_READ_LABEL, 0, 1, 0, 0);
    send(FN_READ_TGT, 1, 0, 0, 0);

    while (items < ITEM_GOAL) begin
      jobs++;
      nf = $urandom_range(0, 8);
      fi = $urandom_range(0, 8);
      ns = $urandom_range(0, 4);
      case (jobs)
        2: begin nf = 64; fi = 127; ns = 1; end     // row count extremes, saturated
        4: begin nf = 3; fi = 2; ns = 31; end       // symbol count saturated
        5: begin nf = 2; fi = 3; ns = 16; end
        6: begin nf = 5; fi = 4; ns = 0; end        // nothing compared, all rows merge
        7: begin nf = 0; fi = 0; end
        default: ;
      endcase
      quiet <= (jobs >= 9 && jobs <= 12);
      setup(nf, fi, ns);
      hold_req <= (jobs == 3);
      load_job(nf, fi, ns, jobs == 2 ? 3 : $urandom_range(2, 6));
      mixed_traffic(40, nf > 64 ? 64 : nf, fi > 64 ? 64 : fi);
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (waiting != 0);
    repeat (20) @(posedge clk);
    $display("covered %0d requests over %0d table jobs, %0d merge runs",
             items, jobs, runs);
    $display("counts up to saturation, zero to full symbol range, long receiver hold");
    if (errors == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule

>>> filelist.f
rtl/dfa_merge_pkg.sv
rtl/dfa_merge_ctrl.sv
rtl/dfa_merge_dp.sv
rtl/dfa_duplicate_state_merger_unit.sv
tb/sv/tb_merge_checker.sv
tb/sv/tb.sv
